>>> rtl/core/bffa_pkg.sv
package bffa_pkg;

  localparam int unsigned ENTRY_W  = 14;
  localparam int unsigned STATUS_W = 2;

  localparam logic [ENTRY_W-1:0] LIMIT_RESET = 14'd8192;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_e;

endpackage

>>> rtl/core/bitmap_first_free_allocator_core.sv
// Channel   Direction  Handshake                       Payload
// request   in         start_i && !busy_o              req_type_i, entry_number_i
// result    out        done_o (one-cycle strobe)       status_o, granted_number_o,
//                                                      free_remaining_o
// config    in         entry_limit_we_i                entry_limit_i
//
// The bitmap sits in a RAM of WORD_W-bit words, read-modify-write, one read per cycle.
// Allocate: scans bitmap words in order from word 0 until a free entry below the limit
// is found or the last word within the limit is read (DEPTH = NUM_ENTRIES/WORD_W, 256 with defaults).
// Free: reads the word that holds the entry, then updates it. Out of range free or zero limit: no scan.
// After reset the block clears the RAM, one word a cycle, with busy_o high.
// The result strobe cannot be stalled; busy_o is low while done_o is high.
module bitmap_first_free_allocator_core import bffa_pkg::*; #(
  parameter int unsigned NUM_ENTRIES = 8192,
  parameter int unsigned WORD_W      = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [ENTRY_W-1:0] entry_number_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [ENTRY_W-1:0] granted_number_o,
  output logic [ENTRY_W-1:0] free_remaining_o,
  input  logic               entry_limit_we_i,
  input  logic [ENTRY_W-1:0] entry_limit_i
);

  localparam int unsigned DEPTH  = (NUM_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OFF_W  = $clog2(WORD_W);
  localparam int unsigned IDX_W  = AW + OFF_W;
  localparam int unsigned CNT_W  = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned CMP_A  = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
  localparam int unsigned CMP_W  = (CMP_A > IDX_W + 1) ? CMP_A : IDX_W + 1;

  state_e             state_q, state_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [ENTRY_W-1:0] limit_q;
  logic [CNT_W-1:0]   used_q, used_d;
  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [ENTRY_W-1:0] granted_q, granted_d;
  logic [ENTRY_W-1:0] remain_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic [CMP_W-1:0]   lim_c, base_c, rem_c, num_c, pos_c, remain_c;
  logic               full_word_c, last_word_c, num_bad_c, found_c, is_alloc_c;
  logic [WORD_W-1:0]  mask_c, cand_c;
  logic [OFF_W-1:0]   hit_c;

  bffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign lim_c = (CMP_W'(limit_q) < CMP_W'(NUM_ENTRIES)) ? CMP_W'(limit_q)
                                                         : CMP_W'(NUM_ENTRIES);
  assign base_c      = CMP_W'({addr_q, {OFF_W{1'b0}}});
  assign rem_c       = lim_c - base_c;
  assign full_word_c = rem_c >= CMP_W'(WORD_W);
  assign last_word_c = rem_c <= CMP_W'(WORD_W);
  assign num_c       = CMP_W'(entry_number_i);
  assign num_bad_c   = (num_c == '0) || (num_c > CMP_W'(NUM_ENTRIES));
  assign pos_c       = num_c - CMP_W'(1);
  assign is_alloc_c  = (req_e'(req_type_i) == REQ_ALLOC);

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      mask_c[j] = full_word_c || (OFF_W'(j) < rem_c[OFF_W-1:0]);
    end
  end

  assign cand_c = ~ram_rdata & mask_c;

  always_comb begin
    found_c = 1'b0;
    hit_c   = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand_c[j]) begin
        found_c = 1'b1;
        hit_c   = OFF_W'(j);
      end
    end
  end

  assign remain_c = (lim_c > CMP_W'(used_d)) ? (lim_c - CMP_W'(used_d)) : '0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (addr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          if (is_alloc_c) begin
            if (lim_c != '0) state_d = S_SCAN;
          end else if (!num_bad_c) begin
            state_d = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (found_c || last_word_c) state_d = S_IDLE;
      end
      S_FREE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = ram_rdata;
    ram_raddr = addr_q;
    addr_d    = addr_q;
    off_d     = off_q;
    used_d    = used_q;
    done_d    = 1'b0;
    status_d  = status_q;
    granted_d = granted_q;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        addr_d    = (addr_q == AW'(DEPTH - 1)) ? '0 : addr_q + AW'(1);
      end
      S_IDLE: begin
        if (start_i) begin
          if (is_alloc_c) begin
            ram_raddr = '0;
            addr_d    = '0;
            if (lim_c == '0) begin
              done_d    = 1'b1;
              status_d  = ST_FULL;
              granted_d = '0;
            end
          end else if (num_bad_c) begin
            done_d    = 1'b1;
            status_d  = ST_RANGE;
            granted_d = '0;
          end else begin
            ram_raddr = pos_c[IDX_W-1:OFF_W];
            addr_d    = pos_c[IDX_W-1:OFF_W];
            off_d     = pos_c[OFF_W-1:0];
          end
        end
      end
      S_SCAN: begin
        if (found_c) begin
          ram_we           = 1'b1;
          ram_wdata[hit_c] = 1'b1;
          used_d           = used_q + CNT_W'(1);
          done_d           = 1'b1;
          status_d         = ST_OK;
          granted_d        = ENTRY_W'(base_c + CMP_W'(hit_c) + CMP_W'(1));
        end else if (last_word_c) begin
          done_d    = 1'b1;
          status_d  = ST_FULL;
          granted_d = '0;
        end else begin
          addr_d    = addr_q + AW'(1);
          ram_raddr = addr_q + AW'(1);
        end
      end
      S_FREE: begin
        done_d    = 1'b1;
        granted_d = '0;
        if (ram_rdata[off_q]) begin
          ram_we           = 1'b1;
          ram_wdata[off_q] = 1'b0;
          used_d           = (used_q != '0) ? used_q - CNT_W'(1) : used_q;
          status_d         = ST_OK;
        end else begin
          status_d = ST_ALREADY_FREE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      limit_q <= LIMIT_RESET;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      used_q  <= used_d;
      done_q  <= done_d;
      if (entry_limit_we_i) limit_q <= entry_limit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q     <= off_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    if (done_d) remain_q <= remain_c[ENTRY_W-1:0];
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_number_o = granted_q;
  assign free_remaining_o = remain_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (granted_number_o != '0) |-> (status_o == ST_OK))
    else $error("granted number with failing status");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(NUM_ENTRIES))
    else $error("used count beyond bitmap size");

  a_full_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> (granted_number_o == '0))
    else $error("full status with granted number");

endmodule

>>> rtl/core/bffa_ram.sv
module bffa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
